// ===== sv/aff2d_pkg.sv =====
// Shared types, constants and the sine/cosine table builder for the 2D affine transformer.
`timescale 1ns / 1ps

package aff2d_pkg;

  // Defaults for top-level parameters
  localparam int NUM_POINTS_DEF = 4;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed field and datapath widths
  localparam int COORD_W     = 32;
  localparam int SHIFT_W     = 16;
  localparam int FACTOR_W    = 24;
  localparam int ANGLE_W     = 9;
  localparam int CMD_W       = 3;
  localparam int PIDX_W      = 2;
  localparam int FACTOR_FRAC = 16;
  localparam int TRIG_W      = 18;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = DIFF_W + FACTOR_W;
  localparam int ACC_W       = PROD_W + 1;
  localparam int TRIG_DEPTH  = 1 << ANGLE_W;

  // Angle conversion constants (radians = deg * 22 / 1260)
  localparam longint unsigned ANG_NUM     = 22;
  localparam longint unsigned ANG_DEN     = 1260;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_REF_X = 1'b0,
    REG_REF_Y = 1'b1
  } reg_idx_t;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD      = 3'd0,
    CMD_TRANSLATE = 3'd1,
    CMD_SCALE     = 3'd2,
    CMD_ROTATE    = 3'd3,
    CMD_READ      = 3'd4
  } cmd_t;

  // One table entry: sine and cosine in Q16
  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;

  typedef trig_t [TRIG_DEPTH-1:0] trig_rom_t;

  // Sine and cosine of one angle: Q30 Taylor series, quadrant fold, round to Q16
  function automatic trig_t trig_entry(input longint unsigned deg);
    longint unsigned a;
    longint unsigned k;
    longint          r;
    longint unsigned u;
    longint unsigned u2;
    longint unsigned ts;
    longint unsigned tc;
    longint          s;
    longint          c;
    longint          t;
    trig_t           e;
    a  = (deg * ANG_NUM * (64'd1 << 30) + ANG_DEN / 2) / ANG_DEN;
    k  = (a + HALF_PI_Q30 / 2) / HALF_PI_Q30;
    r  = longint'(a) - longint'(k) * longint'(HALF_PI_Q30);
    u  = (r < 0) ? longint'(-r) : longint'(r);
    u2 = (u * u) >> 30;
    ts = u;
    tc = 64'd1 << 30;
    s  = longint'(ts);
    c  = longint'(tc);
    ts = ((ts * u2) >> 30) / 6;   tc = ((tc * u2) >> 30) / 2;
    s  = s - longint'(ts);        c  = c - longint'(tc);
    ts = ((ts * u2) >> 30) / 20;  tc = ((tc * u2) >> 30) / 12;
    s  = s + longint'(ts);        c  = c + longint'(tc);
    ts = ((ts * u2) >> 30) / 42;  tc = ((tc * u2) >> 30) / 30;
    s  = s - longint'(ts);        c  = c - longint'(tc);
    ts = ((ts * u2) >> 30) / 72;  tc = ((tc * u2) >> 30) / 56;
    s  = s + longint'(ts);        c  = c + longint'(tc);
    ts = ((ts * u2) >> 30) / 110; tc = ((tc * u2) >> 30) / 90;
    s  = s - longint'(ts);        c  = c - longint'(tc);
    ts = ((ts * u2) >> 30) / 156; tc = ((tc * u2) >> 30) / 132;
    s  = s + longint'(ts);        c  = c + longint'(tc);
    if (r < 0) s = -s;
    case (k[1:0])
      2'd0: begin
      end
      2'd1: begin
        t = s; s = c; c = -t;
      end
      2'd2: begin
        s = -s; c = -c;
      end
      default: begin
        t = s; s = -c; c = t;
      end
    endcase
    s   = (s + 64'sd8192) >>> 14;
    c   = (c + 64'sd8192) >>> 14;
    e.s = s[TRIG_W-1:0];
    e.c = c[TRIG_W-1:0];
    return e;
  endfunction

  // Whole table, built at elaboration
  function automatic trig_rom_t build_trig_rom();
    trig_rom_t rom;
    for (int i = 0; i < TRIG_DEPTH; i++) begin
      rom[i] = trig_entry(longint'(i));
    end
    return rom;
  endfunction

endpackage

// ===== sv/affine_2d_point_transformer.sv =====
// Top level: 2D affine point transformer with a shared multiply-accumulate sequencer.
//
// Usage: the block holds NUM_POINTS points in signed fixed point. Requests arrive on
// the in_ channel (valid/ready): load a point, translate, scale or rotate all points
// about the reference point (cfg registers ref_x, ref_y), or read one point.
// Only a read produces a response on the out_ channel (out_x, out_y, out_clipped);
// out_clipped reports any saturation since the previous read and is then cleared.
// Timing: load, read and unused codes leave the sequencer idle; a read response shows up the
// cycle after acceptance. Translate, scale and rotate step through the points in turn,
// bounded by the single 33x24 multiplier and the per-point add/saturate step; in_ready
// stays low while a transform runs.
// The out_ side has an output register: a new request is taken while a response waits
// if out_ready is high in that cycle; otherwise in_ready holds low until it is taken.
// Reset (rst_n low, synchronous) clears all points, the clip flag and the reference point
// and drops out_valid. The user must write configuration only while idle; not enforced.
`timescale 1ns / 1ps

module affine_2d_point_transformer
  import aff2d_pkg::*;
#(
  parameter int NUM_POINTS = NUM_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [COORD_W-1:0]         cfg_wdata,
  // request channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [CMD_W-1:0]           in_cmd,
  input  logic [PIDX_W-1:0]          in_point_index,
  input  logic signed [COORD_W-1:0]  in_load_x,
  input  logic signed [COORD_W-1:0]  in_load_y,
  input  logic signed [SHIFT_W-1:0]  in_shift_x,
  input  logic signed [SHIFT_W-1:0]  in_shift_y,
  input  logic signed [FACTOR_W-1:0] in_factor_x,
  input  logic signed [FACTOR_W-1:0] in_factor_y,
  input  logic [ANGLE_W-1:0]         in_angle_deg,
  // response channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [COORD_W-1:0]  out_x,
  output logic signed [COORD_W-1:0]  out_y,
  output logic                       out_clipped
);

  localparam int IDX_W   = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int TERM_W  = ACC_W - FACTOR_FRAC;
  localparam int TRN_W   = SHIFT_W + FRAC_BITS;
  localparam int SUM_W   = ((TERM_W > TRN_W) ? TERM_W : TRN_W) + 1;
  localparam int XIDX_W  = 5;
  localparam trig_rom_t TRIG_ROM = build_trig_rom();

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_ACC,
    S_FIN
  } state_t;

  state_t                     state_r, state_nxt;
  cmd_t                       cmd_r, cmd_nxt;
  logic [IDX_W-1:0]           cnt_r, cnt_nxt;
  logic [1:0]                 ph_r, ph_nxt;
  logic signed [SHIFT_W-1:0]  sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [FACTOR_W-1:0] fx_r, fx_nxt, fy_r, fy_nxt;
  trig_t                      trig_r, trig_nxt;
  logic signed [DIFF_W-1:0]   dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [COORD_W-1:0]  ref_x_r, ref_x_nxt, ref_y_r, ref_y_nxt;
  logic signed [COORD_W-1:0]  store_x_r [NUM_POINTS];
  logic signed [COORD_W-1:0]  store_x_nxt [NUM_POINTS];
  logic signed [COORD_W-1:0]  store_y_r [NUM_POINTS];
  logic signed [COORD_W-1:0]  store_y_nxt [NUM_POINTS];
  logic                       clip_r, clip_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [COORD_W-1:0]  out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                       out_clip_r, out_clip_nxt;

  logic                       in_acc;
  logic [XIDX_W-1:0]          in_idx_ext;
  logic                       in_idx_ok;
  logic [IDX_W-1:0]           rd_idx;
  logic signed [COORD_W-1:0]  px, py;
  logic                       is_rot, is_trn;
  logic signed [DIFF_W-1:0]   opa;
  logic signed [FACTOR_W-1:0] opb;
  logic signed [FACTOR_W-1:0] sin_ext, cos_ext;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [TERM_W-1:0]   term_mac;
  logic signed [TRN_W-1:0]    term_trn;
  logic signed [COORD_W-1:0]  base;
  logic signed [SUM_W-1:0]    sum;
  logic [SUM_W-32:0]          sum_hi;
  logic                       sum_ok;
  logic signed [COORD_W-1:0]  res;

  assign in_ready    = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc      = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_clipped = out_clip_r;

  // Point index check and shared read address
  assign in_idx_ext = XIDX_W'(in_point_index);
  assign in_idx_ok  = in_idx_ext < XIDX_W'(NUM_POINTS);
  assign rd_idx     = (state_r == S_IDLE) ? in_idx_ext[IDX_W-1:0] : cnt_r;
  assign px         = store_x_r[rd_idx];
  assign py         = store_y_r[rd_idx];

  assign is_rot  = (cmd_r == CMD_ROTATE);
  assign is_trn  = (cmd_r == CMD_TRANSLATE);
  assign sin_ext = FACTOR_W'(trig_r.s);
  assign cos_ext = FACTOR_W'(trig_r.c);

  // Multiplier operand select per phase
  // rotate: c*dx, -s*dy -> x ; s*dx, +c*dy -> y.  scale: fx*dx -> x ; fy*dy -> y
  always_comb begin
    case (ph_r)
      2'd0: begin
        opa = dx_r;
        opb = is_rot ? cos_ext : fx_r;
      end
      2'd1: begin
        opa = dy_r;
        opb = sin_ext;
      end
      2'd2: begin
        opa = is_rot ? dx_r : dy_r;
        opb = is_rot ? sin_ext : fy_r;
      end
      default: begin
        opa = dy_r;
        opb = cos_ext;
      end
    endcase
  end

  // Final add and saturate: ref + rounded sum, or point + whole-unit shift
  assign acc_rnd  = acc_r + ACC_W'(64'sd1 <<< (FACTOR_FRAC - 1));
  assign term_mac = acc_rnd[ACC_W-1:FACTOR_FRAC];
  assign term_trn = {(ph_r[1] ? sy_r : sx_r), {FRAC_BITS{1'b0}}};
  assign base     = is_trn ? (ph_r[1] ? py : px) : (ph_r[1] ? ref_y_r : ref_x_r);
  assign sum      = SUM_W'(base) + (is_trn ? SUM_W'(term_trn) : SUM_W'(term_mac));
  assign sum_hi   = sum[SUM_W-1:31];
  assign sum_ok   = (&sum_hi) || (~|sum_hi);
  assign res      = sum_ok ? sum[COORD_W-1:0] :
                    (sum[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                  : {1'b0, {(COORD_W-1){1'b1}}});

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    ph_nxt        = ph_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    trig_nxt      = trig_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    ref_x_nxt     = ref_x_r;
    ref_y_nxt     = ref_y_r;
    store_x_nxt   = store_x_r;
    store_y_nxt   = store_y_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_clip_nxt  = out_clip_r;

    // configuration writes
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_REF_X: ref_x_nxt = cfg_wdata;
        REG_REF_Y: ref_y_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = cmd_t'(in_cmd);
          cnt_nxt  = '0;
          ph_nxt   = 2'd0;
          sx_nxt   = in_shift_x;
          sy_nxt   = in_shift_y;
          fx_nxt   = in_factor_x;
          fy_nxt   = in_factor_y;
          trig_nxt = TRIG_ROM[in_angle_deg];
          case (cmd_t'(in_cmd))
            CMD_LOAD: begin
              if (in_idx_ok) begin
                store_x_nxt[in_idx_ext[IDX_W-1:0]] = in_load_x;
                store_y_nxt[in_idx_ext[IDX_W-1:0]] = in_load_y;
              end
            end
            CMD_TRANSLATE: state_nxt = S_FIN;
            CMD_SCALE:     state_nxt = S_DIFF;
            CMD_ROTATE:    state_nxt = S_DIFF;
            CMD_READ: begin
              out_valid_nxt = 1'b1;
              out_x_nxt     = in_idx_ok ? px : '0;
              out_y_nxt     = in_idx_ok ? py : '0;
              out_clip_nxt  = clip_r;
              clip_nxt      = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      // offsets from the reference point
      S_DIFF: begin
        dx_nxt    = DIFF_W'(px) - DIFF_W'(ref_x_r);
        dy_nxt    = DIFF_W'(py) - DIFF_W'(ref_y_r);
        ph_nxt    = 2'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = opa * opb;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        case (ph_r)
          2'd1:    acc_nxt = acc_r - ACC_W'(prod_r);
          2'd3:    acc_nxt = acc_r + ACC_W'(prod_r);
          default: acc_nxt = ACC_W'(prod_r);
        endcase
        if (is_rot && !ph_r[0]) begin
          ph_nxt    = ph_r + 2'd1;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!sum_ok) clip_nxt = 1'b1;
        if (!ph_r[1]) begin
          store_x_nxt[cnt_r] = res;
          ph_nxt             = 2'd2;
          state_nxt          = is_trn ? S_FIN : S_MUL;
        end else begin
          store_y_nxt[cnt_r] = res;
          ph_nxt             = 2'd0;
          if (cnt_r == IDX_W'(NUM_POINTS - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + IDX_W'(1);
            state_nxt = is_trn ? S_FIN : S_DIFF;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_r       <= CMD_LOAD;
      cnt_r       <= '0;
      ph_r        <= 2'd0;
      ref_x_r     <= '0;
      ref_y_r     <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_POINTS; i++) begin
        store_x_r[i] <= '0;
        store_y_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      cnt_r       <= cnt_nxt;
      ph_r        <= ph_nxt;
      ref_x_r     <= ref_x_nxt;
      ref_y_r     <= ref_y_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
      store_x_r   <= store_x_nxt;
      store_y_r   <= store_y_nxt;
    end
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    fx_r       <= fx_nxt;
    fy_r       <= fy_nxt;
    trig_r     <= trig_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_clip_r <= out_clip_nxt;
  end

`ifndef ASSERT_OFF
  // a transform request must start the sequencer
  a_xform_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_cmd == CMD_TRANSLATE || in_cmd == CMD_SCALE || in_cmd == CMD_ROTATE)
    |=> state_r != S_IDLE)
    else $error("transform request did not start the sequencer");

  // a read always leaves the clip flag cleared
  a_read_clears_clip: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_cmd == CMD_READ |=> !clip_r)
    else $error("clip flag not cleared by read");

  // scale only uses the single-product phases
  a_scale_even_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE && cmd_r == CMD_SCALE |-> !ph_r[0])
    else $error("scale entered a rotate-only phase");

  // point counter stays inside the store while busy
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> 32'(cnt_r) < NUM_POINTS)
    else $error("point counter out of range");
`endif

endmodule
